// File: rtl/montgomery_modular_multiplier_defines.svh
// Assertion helpers for the Montgomery multiplier; sampled on i_clk, off during reset.
`ifndef MONTGOMERY_MODULAR_MULTIPLIER_DEFINES_SVH
`define MONTGOMERY_MODULAR_MULTIPLIER_DEFINES_SVH

// Same-cycle implication.
`define MMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mmm_pkg.sv
package mmm_pkg;

    // Datapath width and derived sizes
    localparam int W    = 64;
    localparam int H    = W / 2;
    localparam int PW   = 2 * W;
    localparam int FW   = 64;
    localparam int RBW  = 7;
    localparam int IDXW = 2;
    localparam int NST  = 7;

    typedef enum logic [IDXW-1:0] {
        REG_MODULUS,
        REG_N_PRIME,
        REG_R_SQUARED,
        REG_R_BITS
    } t_reg_idx;

    localparam logic ACT_MUL  = 1'b0;
    localparam logic ACT_REDC = 1'b1;

    // Constants seen by every reduction unit
    typedef struct packed {
        logic [W-1:0]   n;
        logic [W-1:0]   np;
        logic [RBW-1:0] rb;
    } t_cfg;

    // Item data carried alongside the arithmetic
    typedef struct packed {
        logic         action;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
    } t_side;

    // Half-width partial products
    typedef struct packed {
        logic [W-1:0] p00;
        logic [W-1:0] p01;
        logic [W-1:0] p10;
        logic [W-1:0] p11;
    } t_pp;

    function automatic t_pp pp_mul(input logic [W-1:0] x, input logic [W-1:0] y);
        t_pp p;
        p.p00 = x[H-1:0] * y[H-1:0];
        p.p01 = x[H-1:0] * y[W-1:H];
        p.p10 = x[W-1:H] * y[H-1:0];
        p.p11 = x[W-1:H] * y[W-1:H];
        return p;
    endfunction

    // Full double-width product from partials
    function automatic logic [PW-1:0] pp_sum(input t_pp p);
        logic [PW-1:0] s;
        s = {{W{1'b0}}, p.p00} + ({{W{1'b0}}, p.p01} << H)
            + ({{W{1'b0}}, p.p10} << H) + {p.p11, {W{1'b0}}};
        return s;
    endfunction

    // Product modulo 2^W from partials
    function automatic logic [W-1:0] pp_low(input t_pp p);
        logic [W-1:0] s;
        s = p.p00 + {p.p01[H-1:0], {H{1'b0}}} + {p.p10[H-1:0], {H{1'b0}}};
        return s;
    endfunction

    function automatic logic [W-1:0] rb_mask(input logic [RBW-1:0] rb);
        logic [W-1:0] m;
        m = {W{1'b1}} >> (W - int'(rb));
        return m;
    endfunction

endpackage

// File: rtl/mmm_if.sv
interface mmm_in_if;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [mmm_pkg::FW-1:0]  operand_a;
    logic [mmm_pkg::FW-1:0]  operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface mmm_out_if;
    logic                    valid;
    logic                    ready;
    logic [mmm_pkg::FW-1:0]  result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

interface mmm_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [mmm_pkg::IDXW-1:0] index;
    logic [mmm_pkg::FW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/montgomery_modular_multiplier.sv
// Channel  Dir  Fields                          Handshake
// i_in     in   action, operand_a, operand_b    valid/ready
// o_out    out  result                          valid/ready
// i_cfg    in   index, data                     valid/ready (always ready)
//
// One item per cycle while the skid register is empty; the path into the
// output register runs product, REDC, product, REDC, REDC.
// Each REDC unit: 7-stage chain of 32x32 partial products, wide add, shift, subtract.
// Synchronous active-low reset clears valid bits and restores the register defaults.
// The whole pipeline holds while the skid register is full; the output register
// plus skid let one more item land while a result waits.
module montgomery_modular_multiplier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmm_in_if.sink     i_in,
    mmm_out_if.source  o_out,
    mmm_cfg_if.sink    i_cfg
);

`include "montgomery_modular_multiplier_defines.svh"

    logic [mmm_pkg::W-1:0]    r_modulus, r_n_prime, r_r_squared;
    logic [mmm_pkg::RBW-1:0]  r_r_bits;
    mmm_pkg::t_cfg            w_cfg;

    logic                     w_en, w_acc;
    mmm_pkg::t_side           w_side_in;
    logic [mmm_pkg::W-1:0]    w_a, w_b;

    logic                     w_ma_v;
    logic [mmm_pkg::PW-1:0]   w_ma_p, w_mb_p;
    mmm_pkg::t_side           w_ma_s;
    logic                     w_ra_v;
    logic [mmm_pkg::W-1:0]    w_xa, w_xb;
    mmm_pkg::t_side           w_ra_s;
    logic                     w_mz_v;
    logic [mmm_pkg::PW-1:0]   w_mz_p;
    mmm_pkg::t_side           w_mz_s;
    logic                     w_rz_v;
    logic [mmm_pkg::W-1:0]    w_z1;
    mmm_pkg::t_side           w_rz_s;
    logic [mmm_pkg::PW-1:0]   w_tf;
    logic                     w_fin_valid;
    logic [mmm_pkg::W-1:0]    w_fin;

    logic                     r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;
    logic [mmm_pkg::W-1:0]    r_out, r_skid, n_out, n_skid;
    logic                     w_take;

    // Configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= mmm_pkg::W'(1);
            r_n_prime   <= '0;
            r_r_squared <= '0;
            r_r_bits    <= mmm_pkg::RBW'(64);
        end else if (i_cfg.valid) begin
            unique case (mmm_pkg::t_reg_idx'(i_cfg.index))
                mmm_pkg::REG_MODULUS:   r_modulus   <= i_cfg.data[mmm_pkg::W-1:0];
                mmm_pkg::REG_N_PRIME:   r_n_prime   <= i_cfg.data[mmm_pkg::W-1:0];
                mmm_pkg::REG_R_SQUARED: r_r_squared <= i_cfg.data[mmm_pkg::W-1:0];
                mmm_pkg::REG_R_BITS:    r_r_bits    <= i_cfg.data[mmm_pkg::RBW-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the exponent to 1..W
    always_comb begin
        w_cfg.n  = r_modulus;
        w_cfg.np = r_n_prime;
        if (r_r_bits == '0) begin
            w_cfg.rb = mmm_pkg::RBW'(1);
        end else if (r_r_bits > mmm_pkg::RBW'(mmm_pkg::W)) begin
            w_cfg.rb = mmm_pkg::RBW'(mmm_pkg::W);
        end else begin
            w_cfg.rb = r_r_bits;
        end
    end

    // Input side
    assign w_en        = !r_skid_valid;
    assign i_in.ready  = w_en;
    assign w_acc       = i_in.valid && w_en;
    assign w_a         = i_in.operand_a[mmm_pkg::W-1:0];
    assign w_b         = i_in.operand_b[mmm_pkg::W-1:0];
    assign w_side_in   = '{action: i_in.action, lo: w_a, hi: w_b};

    // Into Montgomery form: REDC(a*R^2), REDC(b*R^2)
    mmm_mul u_mul_a (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_acc), .i_x(w_a), .i_y(r_r_squared),
        .i_side(w_side_in), .o_valid(w_ma_v), .o_prod(w_ma_p), .o_side(w_ma_s)
    );
    mmm_mul u_mul_b (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_acc), .i_x(w_b), .i_y(r_r_squared),
        .i_side(w_side_in), .o_valid(), .o_prod(w_mb_p), .o_side()
    );
    mmm_redc u_redc_a (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_ma_v), .i_t(w_ma_p), .i_side(w_ma_s),
        .i_cfg(w_cfg), .o_valid(w_ra_v), .o_y(w_xa), .o_side(w_ra_s)
    );
    mmm_redc u_redc_b (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_ma_v), .i_t(w_mb_p), .i_side(w_ma_s),
        .i_cfg(w_cfg), .o_valid(), .o_y(w_xb), .o_side()
    );

    // Montgomery product
    mmm_mul u_mul_z (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_ra_v), .i_x(w_xa), .i_y(w_xb),
        .i_side(w_ra_s), .o_valid(w_mz_v), .o_prod(w_mz_p), .o_side(w_mz_s)
    );
    mmm_redc u_redc_z (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_mz_v), .i_t(w_mz_p), .i_side(w_mz_s),
        .i_cfg(w_cfg), .o_valid(w_rz_v), .o_y(w_z1), .o_side(w_rz_s)
    );

    // Final REDC: out of Montgomery form, or the plain reduction of high:low
    assign w_tf = (w_rz_s.action == mmm_pkg::ACT_REDC) ? {w_rz_s.hi, w_rz_s.lo}
                                                        : {{mmm_pkg::W{1'b0}}, w_z1};
    mmm_redc u_redc_f (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_rz_v), .i_t(w_tf), .i_side(w_rz_s),
        .i_cfg(w_cfg), .o_valid(w_fin_valid), .o_y(w_fin), .o_side()
    );

    // Output register with skid
    assign w_take = r_out_valid && o_out.ready;
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_take) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (w_en && w_fin_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_fin;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = mmm_pkg::FW'(r_out);

    // Checks on the skid logic
    `MMM_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `MMM_ASSERT_NEXT(a_skid_fill, w_fin_valid && w_en && r_out_valid && !o_out.ready, r_skid_valid, "result dropped under stall")
    `MMM_ASSERT_NEXT(a_skid_drain, r_skid_valid, r_out_valid, "output lost while skid held item")

endmodule

// File: rtl/mmm_mul.sv
module mmm_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [mmm_pkg::W-1:0]   i_x,
    input  logic [mmm_pkg::W-1:0]   i_y,
    input  mmm_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [mmm_pkg::PW-1:0]  o_prod,
    output mmm_pkg::t_side          o_side
);

    logic                    r_v1, r_v2;
    mmm_pkg::t_pp            r_pp;
    mmm_pkg::t_side          r_side1, r_side2;
    logic [mmm_pkg::PW-1:0]  r_prod;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Partial products, then their sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp    <= mmm_pkg::pp_mul(i_x, i_y);
            r_side1 <= i_side;
            r_prod  <= mmm_pkg::pp_sum(r_pp);
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_side2;

endmodule

// File: rtl/mmm_redc.sv
module mmm_redc (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [mmm_pkg::PW-1:0]  i_t,
    input  mmm_pkg::t_side          i_side,
    input  mmm_pkg::t_cfg           i_cfg,
    output logic                    o_valid,
    output logic [mmm_pkg::W-1:0]   o_y,
    output mmm_pkg::t_side          o_side
);

    logic [mmm_pkg::NST-1:0]  r_v;
    mmm_pkg::t_side           r_side [mmm_pkg::NST];
    logic [mmm_pkg::PW-1:0]   r_t [4];
    mmm_pkg::t_pp             r_mp, r_mnp;
    logic [mmm_pkg::W-1:0]    r_m;
    logic [mmm_pkg::PW-1:0]   r_mn;
    logic [mmm_pkg::PW:0]     r_s;
    logic [mmm_pkg::W-1:0]    r_y0;
    logic                     r_y1nz;
    logic [mmm_pkg::W-1:0]    r_res;
    logic [mmm_pkg::W-1:0]    w_mask;
    logic [mmm_pkg::PW:0]     w_sh;

    assign w_mask = mmm_pkg::rb_mask(i_cfg.rb);
    assign w_sh   = r_s >> i_cfg.rb;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[mmm_pkg::NST-2:0], i_valid};
        end
    end

    // Carry item data along
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < mmm_pkg::NST; k++) r_side[k] <= r_side[k-1];
            r_t[0] <= i_t;
            for (int k = 1; k < 4; k++) r_t[k] <= r_t[k-1];
        end
    end

    // m = t*n' mod R, y = (t + m*n) / R, one conditional subtract
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mp   <= mmm_pkg::pp_mul(i_t[mmm_pkg::W-1:0] & w_mask, i_cfg.np);
            r_m    <= mmm_pkg::pp_low(r_mp) & w_mask;
            r_mnp  <= mmm_pkg::pp_mul(r_m, i_cfg.n);
            r_mn   <= mmm_pkg::pp_sum(r_mnp);
            r_s    <= {1'b0, r_t[3]} + {1'b0, r_mn};
            r_y0   <= w_sh[mmm_pkg::W-1:0];
            r_y1nz <= |w_sh[mmm_pkg::PW:mmm_pkg::W];
            r_res  <= (r_y1nz || r_y0 >= i_cfg.n) ? r_y0 - i_cfg.n : r_y0;
        end
    end

    assign o_valid = r_v[mmm_pkg::NST-1];
    assign o_y     = r_res;
    assign o_side  = r_side[mmm_pkg::NST-1];

endmodule
